FILE: src/dtde_pkg.sv
// ----------------------------------------------------------------------------
// Debug text decimal emitter package
// Request and result payload types, request kinds and ASCII constants.
// ----------------------------------------------------------------------------
package dtde_pkg;

  localparam int INT_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;

  localparam logic [1:0] REQ_RAW  = 2'd0;
  localparam logic [1:0] REQ_TEXT = 2'd1;
  localparam logic [1:0] REQ_INT  = 2'd2;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_CR    = 8'h0D;
  localparam logic [7:0] ASCII_LF    = 8'h0A;
  localparam logic [7:0] ASCII_NUL   = 8'h00;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [7:0]              char_in;
    logic signed [INT_W-1:0] int_value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       to_wired;
    logic       to_wireless;
    logic       last_byte;
  } out_t;

endpackage

FILE: src/debug_text_decimal_emitter_top.sv
// ----------------------------------------------------------------------------
// Debug text decimal emitter
// Formats raw characters, text characters (LF expanded to CR LF) and signed
// 32-bit integers (decimal ASCII) into a byte stream tagged with sink enables.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | input     | in_valid/in_stall  | in_data  (req, char, int)
//   out     | output    | out_valid/out_stall| out_data (byte, sinks, last)
//   cfg     | input     | cfg_we             | cfg_wdata (sink mask)
//
// One item at a time. Characters go out at one byte per cycle while the output
// does not stall. An integer is taken in at transfer, then converted by a
// 32-step bit-serial double dabble, then sent by 10 digit shifts.
// Output stalls hold the block back, except that a minus sign may wait
// during the conversion at no cost; a byte waits in the output register
// while the next is prepared. Reset is synchronous: sink mask returns to 1.
// ----------------------------------------------------------------------------
module debug_text_decimal_emitter_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  dtde_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output dtde_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_wdata
);
  import dtde_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHAR = 2'd1;
  localparam logic [1:0] S_CONV = 2'd2;
  localparam logic [1:0] S_DIG  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       mask_r;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;
  logic [INT_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt, bcd_adj;
  logic [4:0]       bit_cnt_r, bit_cnt_nxt;
  logic [3:0]       dig_cnt_r, dig_cnt_nxt;
  logic             seen_r, seen_nxt;

  logic             out_free;
  logic             in_xfer;
  logic [3:0]       top_dig;
  logic             last_dig;
  logic [INT_W-1:0] in_bits;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_xfer  = in_valid && !in_stall;
  assign in_bits  = in_data.int_value;
  assign top_dig  = bcd_r[BCD_W-1 -: 4];
  assign last_dig = (dig_cnt_r == 4'(NUM_DIGITS - 1));

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    seen_nxt      = seen_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          out_data_nxt.to_wired    = mask_r[0];
          out_data_nxt.to_wireless = mask_r[1];
          out_data_nxt.out_byte    = in_data.char_in;
          out_data_nxt.last_byte   = 1'b1;
          unique case (in_data.req_type)
            REQ_RAW: begin
              out_valid_nxt = 1'b1;
            end
            REQ_TEXT: begin
              if (in_data.char_in == ASCII_LF) begin
                out_valid_nxt          = 1'b1;
                out_data_nxt.out_byte  = ASCII_CR;
                out_data_nxt.last_byte = 1'b0;
                state_nxt              = S_CHAR;
              end else if (in_data.char_in != ASCII_NUL) begin
                out_valid_nxt = 1'b1;
              end
            end
            REQ_INT: begin
              out_data_nxt.out_byte  = ASCII_MINUS;
              out_data_nxt.last_byte = 1'b0;
              out_valid_nxt          = in_bits[INT_W-1];
              mag_nxt     = in_bits[INT_W-1] ? (~in_bits + INT_W'(1)) : in_bits;
              bcd_nxt     = '0;
              bit_cnt_nxt = '0;
              state_nxt   = S_CONV;
            end
            default: begin
              // unused kind: drop the item
            end
          endcase
        end
      end
      S_CHAR: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_byte    = ASCII_LF;
          out_data_nxt.to_wired    = mask_r[0];
          out_data_nxt.to_wireless = mask_r[1];
          out_data_nxt.last_byte   = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      S_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[INT_W-1]};
        mag_nxt     = {mag_r[INT_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 5'd1;
        if (bit_cnt_r == 5'(INT_W - 1)) begin
          dig_cnt_nxt = '0;
          seen_nxt    = 1'b0;
          state_nxt   = S_DIG;
        end
      end
      S_DIG: begin
        // skip leading zeros; the last digit always goes out
        if ((top_dig != 4'd0) || seen_r || last_dig) begin
          if (out_free) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.out_byte    = ASCII_ZERO | {4'd0, top_dig};
            out_data_nxt.to_wired    = mask_r[0];
            out_data_nxt.to_wireless = mask_r[1];
            out_data_nxt.last_byte   = last_dig;
            seen_nxt                 = 1'b1;
            bcd_nxt                  = {bcd_r[BCD_W-5:0], 4'd0};
            dig_cnt_nxt              = dig_cnt_r + 4'd1;
            if (last_dig) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r + 4'd1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mask_r      <= 2'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    seen_r     <= seen_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_conv_to_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV && bit_cnt_r == 5'(INT_W - 1)) |=> (state_r == S_DIG))
    else $error("conversion did not hand over to digit output");

  a_xfer_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> (state_r == S_IDLE && out_free))
    else $error("input transfer while busy or output blocked");

  a_bcd_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIG) |-> (top_dig <= 4'd9))
    else $error("BCD digit out of range");

  a_no_last_midconv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV && out_valid_r) |-> !out_data_r.last_byte)
    else $error("last byte flagged before digits were sent");

endmodule

FILE: tb/sv/tb_debug_text_decimal_emitter_top.sv
// ----------------------------------------------------------------------------
// Debug text decimal emitter testbench
// Drives raw characters, text characters and signed integers into the block
// and checks every emitted byte, its sink enables and its last-byte flag
// against a predictor. A directed table covers the extremes and corner cases.
// Random phases then vary the sink mask, sender gaps and receiver stalls,
// with one long output hold-off and one full drain in the middle of a phase.
// ----------------------------------------------------------------------------
module tb_debug_text_decimal_emitter_top;
  import dtde_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         PHASES       = 4;
  localparam int         PHASE_ITEMS  = 72;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         SETTLE_CYCLES = 64;

  typedef struct {
    in_t   req;
    bit    typed;
    string text;
  } directed_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;

  logic [1:0] sink_mask = 2'd1;
  out_t       expected_bytes[$];
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic [7:0] hold_token = 8'd0;
  logic [7:0] hold_seen = 8'd0;
  int         hold_left = 0;

  int         phase_send_pct [PHASES] = '{0, 59, 0, 28};
  int         phase_stall_pct[PHASES] = '{0, 0, 59, 28};
  logic [1:0] phase_mask     [PHASES] = '{2'd3, 2'd0, 2'd2, 2'd1};

  directed_row_t directed_rows[$] = '{
    '{'{REQ_RAW,    8'h41,       32'h0000_0000}, 1'b1, "A"},
    '{'{REQ_RAW,    ASCII_NUL,   32'h0000_0000}, 1'b0, ""},
    '{'{REQ_RAW,    8'hFF,       32'h0000_0000}, 1'b0, ""},
    '{'{REQ_RAW,    ASCII_LF,    32'h0000_0000}, 1'b1, "\n"},
    '{'{REQ_RAW,    8'h71,       32'hFFFF_FFFF}, 1'b1, "q"},
    '{'{REQ_TEXT,   ASCII_LF,    32'h0000_0000}, 1'b1, "\015\n"},
    '{'{REQ_TEXT,   ASCII_NUL,   32'h0000_0000}, 1'b1, ""},
    '{'{REQ_TEXT,   ASCII_CR,    32'h0000_0000}, 1'b1, "\015"},
    '{'{REQ_TEXT,   8'h7A,       32'h8000_0000}, 1'b1, "z"},
    '{'{REQ_TEXT,   8'hFF,       32'h0000_0000}, 1'b0, ""},
    '{'{REQ_TEXT,   8'h80,       32'h7FFF_FFFF}, 1'b0, ""},
    '{'{REQ_INT,    8'h00,       32'h0000_0000}, 1'b1, "0"},
    '{'{REQ_INT,    8'hFF,       32'h0000_007B}, 1'b1, "123"},
    '{'{REQ_INT,    ASCII_LF,    32'hFFFF_FFFF}, 1'b1, "-1"},
    '{'{REQ_INT,    8'h00,       32'h0000_0009}, 1'b1, "9"},
    '{'{REQ_INT,    8'h00,       32'h0000_000A}, 1'b1, "10"},
    '{'{REQ_INT,    8'h00,       32'hFFFF_FFF6}, 1'b1, "-10"},
    '{'{REQ_INT,    8'h00,       32'h3B9A_CA00}, 1'b1, "1000000000"},
    '{'{REQ_INT,    8'h00,       32'h7FFF_FFFF}, 1'b1, "2147483647"},
    '{'{REQ_INT,    8'h00,       32'h8000_0000}, 1'b1, "-2147483648"},
    '{'{REQ_INT,    8'h00,       32'h5555_5555}, 1'b0, ""},
    '{'{REQ_INT,    8'h00,       32'hAAAA_AAAA}, 1'b0, ""},
    '{'{REQ_INT,    8'h00,       32'hC465_3601}, 1'b0, ""},
    '{'{REQ_UNUSED, 8'h41,       32'h0000_0001}, 1'b1, ""},
    '{'{REQ_UNUSED, 8'hFF,       32'hFFFF_FFFF}, 1'b1, ""}
  };

  debug_text_decimal_emitter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Tag each byte with the current sink mask and flag the final one.
  function automatic void queue_burst(input logic [7:0] text[$]);
    out_t item;
    foreach (text[i]) begin
      item.out_byte    = text[i];
      item.to_wired    = sink_mask[0];
      item.to_wireless = sink_mask[1];
      item.last_byte   = (i == text.size() - 1);
      expected_bytes.push_back(item);
    end
  endfunction

  function automatic int predict_burst(input in_t req);
    logic [7:0]  text[$];
    logic [7:0]  digits[$];
    logic [31:0] mag;
    case (req.req_type)
      REQ_RAW: text.push_back(req.char_in);
      REQ_TEXT: begin
        if (req.char_in != ASCII_NUL) begin
          if (req.char_in == ASCII_LF) text.push_back(ASCII_CR);
          text.push_back(req.char_in);
        end
      end
      REQ_INT: begin
        mag = req.int_value;
        if (mag[31]) begin
          text.push_back(ASCII_MINUS);
          mag = -mag;  // wraps to 2^31 for the most negative value
        end
        do begin
          digits.push_front(ASCII_ZERO + 8'(mag % 10));
          mag = mag / 10;
        end while (mag != 0);
        text = {text, digits};
      end
      default: ;
    endcase
    queue_burst(text);
    return text.size();
  endfunction

  function automatic in_t random_request();
    in_t         req;
    int          pick;
    logic [31:0] value;
    pick = $urandom_range(99);
    req.req_type = (pick < 4)  ? REQ_UNUSED :
                   (pick < 34) ? REQ_RAW :
                   (pick < 60) ? REQ_TEXT : REQ_INT;
    pick = $urandom_range(99);
    req.char_in = (pick < 10) ? ASCII_LF : (pick < 15) ? ASCII_NUL : 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      value = $urandom;
    end else if (pick < 60) begin
      value = $urandom_range(999);
      if ($urandom_range(1)) value = -value;
    end else if (pick < 80) begin
      // land around a power of ten to exercise digit-count boundaries
      value = 1;
      repeat ($urandom_range(9)) value = value * 10;
      value = value + $urandom_range(2) - 1;
      if ($urandom_range(1)) value = -value;
    end else begin
      case ($urandom_range(3))
        0:       value = 32'h0000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'h8000_0000;
        default: value = 32'hFFFF_FFFF;
      endcase
    end
    req.int_value = value;
    return req;
  endfunction

  // Hold valid high until the transfer happens; valid stays high on return.
  task automatic send_request(input in_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Drop valid and wait until every expected byte has arrived and the block
  // has had time to finish an item that produces no bytes.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sink_mask(input logic [1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sink_mask = value;
  endtask

  task automatic note_mismatch(input string what, input out_t got, input out_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $write("%s: got byte %02h wired %b wireless %b last %b, ",
             what, got.out_byte, got.to_wired, got.to_wireless, got.last_byte);
      $display("expected byte %02h wired %b wireless %b last %b",
               want.out_byte, want.to_wired, want.to_wireless, want.last_byte);
    end
  endtask

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_output
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch("unexpected byte", out_data, '0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.to_wired !== want.to_wired ||
            out_data.to_wireless !== want.to_wireless ||
            out_data.last_byte !== want.last_byte)
          note_mismatch("byte mismatch", out_data, want);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] burst[$];
    in_t        req;
    int         counted;
    bit         paused;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].req);
      if (directed_rows[r].typed) begin
        burst = {};
        for (int i = 0; i < directed_rows[r].text.len(); i++)
          burst.push_back(directed_rows[r].text[i]);
        queue_burst(burst);
      end else begin
        void'(predict_burst(directed_rows[r].req));
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_for_drain();
      write_sink_mask(phase_mask[p]);
      send_idle_pct = phase_send_pct[p];
      stall_pct <= phase_stall_pct[p];
      // back up the output while the sender keeps offering items
      if (p == 0) hold_token <= hold_token + 8'd1;
      counted = 0;
      paused  = 1'b0;
      while (counted < PHASE_ITEMS) begin
        req = random_request();
        send_request(req);
        if (predict_burst(req) > 0) counted++;
        if (p == 1 && counted == PHASE_ITEMS / 2 && !paused) begin
          paused = 1'b1;
          wait_for_drain();
        end else begin
          sender_gap();
        end
      end
    end

    wait_for_drain();
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
